FILE: hdl/smdr_pkg.sv
// Shared types and constants for the signed multiply-divide-round core.
// No dependencies; every other file in hdl imports this package.
package smdr_pkg;

    localparam int unsigned OP_W      = 32;
    localparam int unsigned DIV_STEPS = 32;
    localparam logic [OP_W-1:0] MAG_LIMIT = 32'h7fff_ffff;

    // Partial division state handed from one restoring cell to the next.
    // work holds the not-yet-consumed dividend bits in its upper part and
    // the quotient bits produced so far in its lower part.
    typedef struct packed {
        logic [OP_W-1:0] rem;
        logic [OP_W-1:0] work;
        logic [OP_W-1:0] mc;
        logic            neg;
        logic            ovf;
    } smdr_div_t;

endpackage

FILE: hdl/smdr_mul_stage.sv
// Front end: operand magnitudes, sign, and the exact 64-bit product.
// Depends on smdr_pkg. Two registered stages with valid/ready handshake.
module smdr_mul_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [31:0]             a,
    input  logic [31:0]             b,
    input  logic [31:0]             c,
    output logic                    out_valid,
    input  logic                    out_ready,
    output smdr_pkg::smdr_div_t     out_data
);
    import smdr_pkg::*;

    logic                s1_valid_reg;
    logic [OP_W-1:0]     ma_reg;
    logic [OP_W-1:0]     mb_reg;
    logic [OP_W-1:0]     mc1_reg;
    logic                neg1_reg;
    logic                zero1_reg;
    logic                s1_ready;

    logic                s2_valid_reg;
    logic [2*OP_W-1:0]   prod_reg;
    logic [OP_W-1:0]     mc2_reg;
    logic                neg2_reg;
    logic                zero2_reg;

    logic [OP_W-1:0]     ma_next;
    logic [OP_W-1:0]     mb_next;
    logic [OP_W-1:0]     mc_next;
    logic [2*OP_W-1:0]   prod_next;

    assign ma_next = a[OP_W-1] ? (~a + 32'd1) : a;
    assign mb_next = b[OP_W-1] ? (~b + 32'd1) : b;
    assign mc_next = c[OP_W-1] ? (~c + 32'd1) : c;
    assign prod_next = {{OP_W{1'b0}}, ma_reg} * {{OP_W{1'b0}}, mb_reg};

    assign s1_ready = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            mc1_reg   <= mc_next;
            neg1_reg  <= a[OP_W-1] ^ b[OP_W-1] ^ c[OP_W-1];
            zero1_reg <= (c == '0);
        end
        if (s1_ready && s1_valid_reg)
        begin
            prod_reg  <= prod_next;
            mc2_reg   <= mc1_reg;
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // Flag a zero divisor or a quotient that would need more than 32 bits.
    assign out_valid     = s2_valid_reg;
    assign out_data.rem  = prod_reg[2*OP_W-1:OP_W];
    assign out_data.work = prod_reg[OP_W-1:0];
    assign out_data.mc   = mc2_reg;
    assign out_data.neg  = neg2_reg;
    assign out_data.ovf  = zero2_reg || (prod_reg[2*OP_W-1:OP_W] >= mc2_reg);

endmodule

FILE: hdl/smdr_div_cell.sv
// One restoring division step with its own pipeline register.
// Depends on smdr_pkg. Instantiated DIV_STEPS times in a chain.
module smdr_div_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  smdr_pkg::smdr_div_t     in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output smdr_pkg::smdr_div_t     out_data
);
    import smdr_pkg::*;

    logic            valid_reg;
    smdr_div_t       data_reg;
    smdr_div_t       data_next;
    logic [OP_W:0]   shifted;
    logic [OP_W:0]   diff;
    logic            ge;

    // Shift in the next dividend bit, subtract when it fits.
    assign shifted = {in_data.rem, in_data.work[OP_W-1]};
    assign diff    = shifted - {1'b0, in_data.mc};
    assign ge      = shifted >= {1'b0, in_data.mc};

    always_comb
    begin
        data_next      = in_data;
        data_next.rem  = ge ? diff[OP_W-1:0] : shifted[OP_W-1:0];
        data_next.work = {in_data.work[OP_W-2:0], ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/smdr_round_stage.sv
// Back end: round half away from zero, range check, sign, output register.
// Depends on smdr_pkg.
module smdr_round_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  smdr_pkg::smdr_div_t     in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [31:0]             quotient,
    output logic                    overflow
);
    import smdr_pkg::*;

    logic            valid_reg;
    logic [OP_W-1:0] quot_reg;
    logic            ovf_reg;

    logic            rnd;
    logic            too_big;
    logic            ovf_next;
    logic [OP_W-1:0] q;
    logic [OP_W-1:0] quot_next;

    assign q   = in_data.work;
    assign rnd = {in_data.rem, 1'b0} >= {1'b0, in_data.mc};

    // q + rnd exceeds the limit when q is already too large or rounds past it.
    assign too_big  = q[OP_W-1] || (rnd && (q == MAG_LIMIT));
    assign ovf_next = in_data.ovf || too_big;

    // -(q + 1) is ~q, so negation and rounding share one adder.
    always_comb
    begin
        if (ovf_next)
        begin
            quot_next = '0;
        end
        else if (in_data.neg)
        begin
            quot_next = rnd ? ~q : (~q + 32'd1);
        end
        else
        begin
            quot_next = q + {{(OP_W-1){1'b0}}, rnd};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            quot_reg <= quot_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign out_valid = valid_reg;
    assign quotient  = quot_reg;
    assign overflow  = ovf_reg;

endmodule

FILE: hdl/signed_muldiv_rounded_core.sv
// Top level of the signed multiply-divide-round core.
// Depends on smdr_pkg, smdr_mul_stage, smdr_div_cell and smdr_round_stage.
//
// Computes a * b / c, rounded half away from zero, on signed 32-bit operands.
// The block accepts one item per clock cycle while in_ready is high. Each
// result passes through the magnitude and 32x32 product registers, the
// register of each of the 32 restoring division cells, and the output
// register for rounding, sign and range check.
// Every stage has its own valid bit and drains independently, so an empty
// slot anywhere in the chain is filled while the output is held. A zero
// divisor, a quotient of 2^32 or more, or a rounded magnitude above 2^31-1
// raises overflow and forces the quotient to zero. Results leave in order.
module signed_muldiv_rounded_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] multiplicand,
    input  logic signed [31:0] multiplier,
    input  logic signed [31:0] divisor,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] quotient,
    output logic               overflow
);
    import smdr_pkg::*;

    // Chain links: index 0 leaves the multiplier, index DIV_STEPS the last cell.
    logic       link_valid [DIV_STEPS+1];
    logic       link_ready [DIV_STEPS+1];
    smdr_div_t  link_data  [DIV_STEPS+1];

    logic [OP_W-1:0] quot_raw;

    // Take magnitudes and form the exact product.
    smdr_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a         ($unsigned(multiplicand)),
        .b         ($unsigned(multiplier)),
        .c         ($unsigned(divisor)),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // Advance the division one quotient bit per cell.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        smdr_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    // Round, sign and hold the result until it is taken.
    smdr_round_stage u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[DIV_STEPS]),
        .in_ready  (link_ready[DIV_STEPS]),
        .in_data   (link_data[DIV_STEPS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quotient  (quot_raw),
        .overflow  (overflow)
    );

    assign quotient = $signed(quot_raw);

endmodule
